### rtl/core/blk2s_pkg.sv
package blk2s_pkg;

   localparam int BLOCK_WORDS = 16;
   localparam int ROUNDS = 10;
   localparam int DIAG_PHASE = 8;
   localparam int LAST_PHASE = 17;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int MAX_DIGEST_BYTES = 32;
   localparam int MAX_KEY_BYTES = 32;
   localparam int KEY_BLOCK_BYTES = 64;

   localparam logic [31:0] PARAM_BASE = 32'h01010000;

   localparam logic CSR_DIGEST_LENGTH = 1'b0;
   localparam logic CSR_KEY_LENGTH = 1'b1;

   localparam logic [31:0] IV_WORDS [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [3:0] PERM_TABLE [10][16] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STORE,
      ST_ROUND,
      ST_FINISH,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic [31:0] word;
      logic store;
      logic [2:0] inc;
      logic start;
      logic last;
      logic pad64;
      logic [5:0] digest_len;
      logic [5:0] key_len;
   } entry_type;

   function automatic logic [31:0] byte_mask(input logic [2:0] n);
      logic [31:0] m;
      case (n)
         3'd0: m = 32'h00000000;
         3'd1: m = 32'h000000FF;
         3'd2: m = 32'h0000FFFF;
         3'd3: m = 32'h00FFFFFF;
         default: m = 32'hFFFFFFFF;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

### rtl/core/blk2s_req_if.sv
interface blk2s_req_if;
   logic valid;
   logic ready;
   logic [31:0] message_word;
   logic [2:0] bytes_valid;
   logic last_word;

   modport source (output valid, message_word, bytes_valid, last_word, input ready);
   modport sink (input valid, message_word, bytes_valid, last_word, output ready);
endinterface

### rtl/core/blk2s_rsp_if.sv
interface blk2s_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] digest_word;
   logic [2:0] word_index;
   logic last_result;

   modport source (output valid, digest_word, word_index, last_result, input ready);
   modport sink (input valid, digest_word, word_index, last_result, output ready);
endinterface

### rtl/core/blk2s_front.sv
module blk2s_front (
   input logic clock,
   input logic reset,
   blk2s_req_if.sink req_channel,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [5:0] csr_write_data,
   input logic queue_full,
   output logic queue_push,
   output blk2s_pkg::entry_type queue_entry
);
   import blk2s_pkg::*;

   logic [5:0] digest_length_ff, digest_length_in;
   logic [5:0] key_length_ff, key_length_in;
   logic start_ff, start_in;
   logic [6:0] count_ff, count_in;

   logic [5:0] dl_eff, ek_eff;
   logic [2:0] bv_eff, inc;
   logic [6:0] count_eff, count_sum, count_after;
   logic keyed, key_phase, store, accept;

   always_comb begin
      if (digest_length_ff == 6'd0) begin
         dl_eff = 6'd1;
      end else if (digest_length_ff > 6'(MAX_DIGEST_BYTES)) begin
         dl_eff = 6'(MAX_DIGEST_BYTES);
      end else begin
         dl_eff = digest_length_ff;
      end
      ek_eff = (key_length_ff > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_length_ff;
      bv_eff = (req_channel.bytes_valid > 3'd4) ? 3'd4 : req_channel.bytes_valid;
      keyed = (ek_eff != 6'd0);
      count_eff = start_ff ? 7'd0 : count_ff;
      key_phase = keyed && (count_eff < 7'(KEY_BLOCK_BYTES));
      store = key_phase || (bv_eff != 3'd0);
      inc = key_phase ? 3'd4 : bv_eff;
      count_sum = count_eff + 7'(inc);
      if (!store) begin
         count_after = count_eff;
      end else if (count_sum > 7'(KEY_BLOCK_BYTES)) begin
         count_after = 7'(KEY_BLOCK_BYTES);
      end else begin
         count_after = count_sum;
      end
      accept = req_channel.valid && !queue_full;
   end

   assign req_channel.ready = !queue_full;
   assign queue_push = accept;

   always_comb begin
      queue_entry.word = req_channel.message_word & byte_mask(bv_eff);
      queue_entry.store = store;
      queue_entry.inc = inc;
      queue_entry.start = start_ff;
      queue_entry.last = req_channel.last_word;
      queue_entry.pad64 = keyed && (count_after < 7'(KEY_BLOCK_BYTES));
      queue_entry.digest_len = dl_eff;
      queue_entry.key_len = ek_eff;
   end

   always_comb begin
      digest_length_in = digest_length_ff;
      key_length_in = key_length_ff;
      start_in = start_ff;
      count_in = count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DIGEST_LENGTH: digest_length_in = csr_write_data;
            CSR_KEY_LENGTH: key_length_in = csr_write_data;
            default: ;
         endcase
      end
      if (accept) begin
         start_in = req_channel.last_word;
         count_in = count_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digest_length_ff <= 6'(MAX_DIGEST_BYTES);
         key_length_ff <= 6'd0;
         start_ff <= 1'b1;
         count_ff <= 7'd0;
      end else begin
         digest_length_ff <= digest_length_in;
         key_length_ff <= key_length_in;
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end
endmodule

### rtl/core/blk2s_queue.sv
module blk2s_queue #(
   parameter int DEPTH = blk2s_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic push,
   input blk2s_pkg::entry_type push_entry,
   output logic full,
   input logic pop,
   output blk2s_pkg::entry_type pop_entry,
   output logic empty
);
   import blk2s_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign pop_entry = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end
endmodule

### rtl/core/blk2s_back.sv
module blk2s_back (
   input logic clock,
   input logic reset,
   input logic queue_empty,
   input blk2s_pkg::entry_type queue_entry,
   output logic queue_pop,
   blk2s_rsp_if.source rsp_channel
);
   import blk2s_pkg::*;

   back_state_type state_ff, state_in;
   entry_type cur_ff, cur_in;
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] buf_ff [16];
   logic [31:0] v_ff [4][4];
   logic [31:0] v_in [4][4];
   logic [4:0] wc_ff, wc_in;
   logic [4:0] fill_ff, fill_in;
   logic [63:0] counter_ff, counter_in;
   logic fin_ff, fin_in;
   logic [4:0] phase_ff, phase_in;
   logic [3:0] round_ff, round_in;
   logic [2:0] k_ff, k_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [2:0] rsp_index_ff, rsp_index_in;
   logic rsp_last_ff, rsp_last_in;

   logic take, buf_write, start_compress, last_round_step, out_load;
   logic [63:0] counter_st, counter_fin, init_counter;
   logic [4:0] fill_st;
   logic [4:0] phase_m1;
   logic [3:0] msg_j, msg_idx;
   logic [31:0] msg_word, ga, gb, gc, gd, ga1, gb1, gc1, gd1;
   logic half_step, second_half;
   logic [31:0] gtmp [4][4];
   logic [3:0] n_words;
   logic [5:0] left;
   logic [2:0] left_bytes;

   always_comb begin
      counter_st = cur_ff.store ? counter_ff + 64'(cur_ff.inc) : counter_ff;
      counter_fin = (cur_ff.pad64 && cur_ff.last) ? 64'(KEY_BLOCK_BYTES) : counter_st;
      fill_st = cur_ff.store ? wc_ff + 5'd1 : wc_ff;
      last_round_step = (phase_ff == 5'(LAST_PHASE)) && (round_ff == 4'(ROUNDS - 1));
      n_words = 4'((7'(cur_ff.digest_len) + 7'd3) >> 2);
      left = cur_ff.digest_len - {1'b0, k_ff, 2'b00};
      left_bytes = (left >= 6'd4) ? 3'd4 : left[2:0];
      out_load = !rsp_valid_ff || rsp_channel.ready;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (cur_ff.store && (wc_ff == 5'(BLOCK_WORDS))) ? ST_ROUND : ST_STORE;
         end
         ST_STORE: begin
            state_in = cur_ff.last ? ST_ROUND : ST_IDLE;
         end
         ST_ROUND: begin
            if (last_round_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = fin_ff ? ST_OUT : ST_STORE;
         end
         ST_OUT: begin
            if (out_load && ({1'b0, k_ff} + 4'd1 == n_words)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      take = 1'b0;
      buf_write = 1'b0;
      start_compress = 1'b0;
      init_counter = counter_ff;
      case (state_ff)
         ST_IDLE: take = !queue_empty;
         ST_CHECK: start_compress = cur_ff.store && (wc_ff == 5'(BLOCK_WORDS));
         ST_STORE: begin
            buf_write = cur_ff.store;
            start_compress = cur_ff.last;
            init_counter = counter_fin;
         end
         default: ;
      endcase
   end

   assign queue_pop = take;

   always_comb begin
      phase_m1 = phase_ff - 5'd1;
      msg_j = (phase_ff < 5'(DIAG_PHASE)) ? phase_ff[3:0] : phase_m1[3:0];
      msg_idx = PERM_TABLE[round_ff][msg_j];
      msg_word = ({1'b0, msg_idx} < fill_ff) ? buf_ff[msg_idx] : 32'h0;
      half_step = (phase_ff != 5'(DIAG_PHASE)) && (phase_ff != 5'(LAST_PHASE));
      second_half = (phase_ff < 5'(DIAG_PHASE)) ? phase_ff[0] : !phase_ff[0];
      ga = v_ff[0][0];
      gb = v_ff[1][0];
      gc = v_ff[2][0];
      gd = v_ff[3][0];
      ga1 = ga + gb + msg_word;
      gd1 = second_half ? rotr32(gd ^ ga1, 8) : rotr32(gd ^ ga1, 16);
      gc1 = gc + gd1;
      gb1 = second_half ? rotr32(gb ^ gc1, 7) : rotr32(gb ^ gc1, 12);
      gtmp = v_ff;
      gtmp[0][0] = ga1;
      gtmp[1][0] = gb1;
      gtmp[2][0] = gc1;
      gtmp[3][0] = gd1;
   end

   always_comb begin
      cur_in = cur_ff;
      chain_in = chain_ff;
      v_in = v_ff;
      wc_in = wc_ff;
      fill_in = fill_ff;
      counter_in = counter_ff;
      fin_in = fin_ff;
      phase_in = phase_ff;
      round_in = round_ff;
      k_in = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in = rsp_last_ff;

      if (rsp_valid_ff && rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (take) begin
         cur_in = queue_entry;
         if (queue_entry.start) begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = IV_WORDS[i];
            end
            chain_in[0] = IV_WORDS[0] ^ PARAM_BASE ^ {18'h0, queue_entry.key_len, 8'h00}
               ^ {26'h0, queue_entry.digest_len};
            counter_in = 64'h0;
            wc_in = 5'd0;
         end
      end

      if (buf_write) begin
         wc_in = wc_ff + 5'd1;
      end
      if (state_ff == ST_STORE) begin
         counter_in = counter_fin;
      end

      if (start_compress) begin
         for (int c = 0; c < 4; c++) begin
            v_in[0][c] = chain_ff[c];
            v_in[1][c] = chain_ff[c + 4];
            v_in[2][c] = IV_WORDS[c];
         end
         v_in[3][0] = IV_WORDS[4] ^ init_counter[31:0];
         v_in[3][1] = IV_WORDS[5] ^ init_counter[63:32];
         v_in[3][2] = cur_ff.last && (state_ff == ST_STORE) ? ~IV_WORDS[6] : IV_WORDS[6];
         v_in[3][3] = IV_WORDS[7];
         fin_in = (state_ff == ST_STORE);
         fill_in = (state_ff == ST_STORE) ? fill_st : 5'(BLOCK_WORDS);
         phase_in = 5'd0;
         round_in = 4'd0;
      end

      if (state_ff == ST_ROUND) begin
         if (half_step) begin
            if (second_half) begin
               for (int r = 0; r < 4; r++) begin
                  for (int c = 0; c < 4; c++) begin
                     v_in[r][c] = gtmp[r][(c + 1) & 3];
                  end
               end
            end else begin
               v_in = gtmp;
            end
         end else if (phase_ff == 5'(DIAG_PHASE)) begin
            for (int r = 0; r < 4; r++) begin
               for (int c = 0; c < 4; c++) begin
                  v_in[r][c] = v_ff[r][(c + r) & 3];
               end
            end
         end else begin
            for (int r = 0; r < 4; r++) begin
               for (int c = 0; c < 4; c++) begin
                  v_in[r][c] = v_ff[r][(c + 4 - r) & 3];
               end
            end
         end
         if (phase_ff == 5'(LAST_PHASE)) begin
            phase_in = 5'd0;
            round_in = round_ff + 4'd1;
         end else begin
            phase_in = phase_ff + 5'd1;
         end
      end

      if (state_ff == ST_FINISH) begin
         for (int c = 0; c < 4; c++) begin
            chain_in[c] = chain_ff[c] ^ v_ff[0][c] ^ v_ff[2][c];
            chain_in[c + 4] = chain_ff[c + 4] ^ v_ff[1][c] ^ v_ff[3][c];
         end
         if (fin_ff) begin
            k_in = 3'd0;
         end else begin
            wc_in = 5'd0;
         end
      end

      if ((state_ff == ST_OUT) && out_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in = chain_ff[k_ff] & byte_mask(left_bytes);
         rsp_index_in = k_ff;
         rsp_last_in = ({1'b0, k_ff} + 4'd1 == n_words);
         k_in = k_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_write) begin
         buf_ff[wc_ff[3:0]] <= cur_ff.word;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      chain_ff <= chain_in;
      v_ff <= v_in;
      fill_ff <= fill_in;
      counter_ff <= counter_in;
      fin_ff <= fin_in;
      phase_ff <= phase_in;
      round_ff <= round_in;
      k_ff <= k_in;
      rsp_word_ff <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wc_ff <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wc_ff <= wc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_channel.valid = rsp_valid_ff;
   assign rsp_channel.digest_word = rsp_word_ff;
   assign rsp_channel.word_index = rsp_index_ff;
   assign rsp_channel.last_result = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset) wc_ff <= 5'(BLOCK_WORDS))
      else $error("Block word count went past a full block.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff < 4'(ROUNDS)) && (phase_ff <= 5'(LAST_PHASE)))
      else $error("Round sequencer left its range.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> ({1'b0, k_ff} < n_words))
      else $error("Digest word index past the digest length.");

   assert property (@(posedge clock) disable iff (reset)
      take |=> (state_ff == ST_CHECK) && !queue_pop)
      else $error("Queue popped while an item was still in progress.");
endmodule

### rtl/core/blake2s_hash_engine.sv
// BLAKE2s hash engine with a digest of 1 to 32 bytes, keyed or unkeyed.
// The req channel takes one little-endian message word per item with its
// count of valid bytes and a last-of-message mark; a keyed message starts
// with the 16-word key block. The csr port sets digest length (index 0) and
// key length (index 1); write it only while the engine is idle.
// A front stage masks and classifies each item and places it in a short
// queue, so items are taken while a block is being compressed.
// The back stage stores words and runs the compression on one shared
// half-G unit, 10 rounds; each round runs the column half-G steps, a
// diagonal rotation, the diagonal half-G steps and a rotation back. The
// item that starts a new block first compresses the full one before it.
// It takes one item at a time; the next one waits in the queue meanwhile.
// After the last item the final block is compressed and the digest goes
// out on the rsp channel as ceil(digest_length / 4) items, one per cycle
// while the receiver is ready, from an output register.
// A stalled receiver holds that register; the back stage then waits and
// the queue fills until req ready drops.
// Reset clears the FSM, counts and rsp valid; no clearing pass is needed.
module blake2s_hash_engine #(
   parameter int QUEUE_DEPTH = blk2s_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   blk2s_req_if.sink req_channel,
   blk2s_rsp_if.source rsp_channel,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [5:0] csr_write_data
);
   import blk2s_pkg::*;

   entry_type push_entry, pop_entry;
   logic push, full, pop, empty;

   blk2s_front u_front (
      .clock(clock),
      .reset(reset),
      .req_channel(req_channel),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .queue_full(full),
      .queue_push(push),
      .queue_entry(push_entry)
   );

   blk2s_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .full(full),
      .pop(pop),
      .pop_entry(pop_entry),
      .empty(empty)
   );

   blk2s_back u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(empty),
      .queue_entry(pop_entry),
      .queue_pop(pop),
      .rsp_channel(rsp_channel)
   );
endmodule

### test/blake2s_hash_engine_checker.sv
`timescale 1ns / 100ps

module blake2s_hash_engine_checker
   import blk2s_pkg::*;
(
   input logic clock,
   input logic reset,
   blk2s_req_if req_channel,
   blk2s_rsp_if rsp_channel,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [5:0] csr_write_data,
   output int fail_count,
   output int pending
);

   typedef struct {
      logic [31:0] word;
      logic [2:0] index;
      logic last;
   } digest_item_type;

   digest_item_type digest_q[$];
   logic [5:0] digest_len_reg;
   logic [5:0] key_len_reg;
   logic [31:0] chain[8];
   logic [31:0] msg_block[16];
   logic [31:0] vec[16];
   int block_fill;
   logic [63:0] byte_total;
   bit at_start;
   int misses;

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] keep_bytes(int n);
      if (n >= 4) return 32'hFFFFFFFF;
      return (32'h1 << (8 * n)) - 32'h1;
   endfunction

   function automatic void mix_g(int a, int b, int c, int d, logic [31:0] x, logic [31:0] y);
      vec[a] = vec[a] + vec[b] + x;
      vec[d] = ror(vec[d] ^ vec[a], 16);
      vec[c] = vec[c] + vec[d];
      vec[b] = ror(vec[b] ^ vec[c], 12);
      vec[a] = vec[a] + vec[b] + y;
      vec[d] = ror(vec[d] ^ vec[a], 8);
      vec[c] = vec[c] + vec[d];
      vec[b] = ror(vec[b] ^ vec[c], 7);
   endfunction

   function automatic void compress_block(bit final_block);
      for (int i = 0; i < 8; i++) begin
         vec[i] = chain[i];
         vec[i + 8] = IV_WORDS[i];
      end
      vec[12] ^= byte_total[31:0];
      vec[13] ^= byte_total[63:32];
      if (final_block) vec[14] = ~vec[14];
      for (int r = 0; r < ROUNDS; r++) begin
         mix_g(0, 4, 8, 12, msg_block[PERM_TABLE[r][0]], msg_block[PERM_TABLE[r][1]]);
         mix_g(1, 5, 9, 13, msg_block[PERM_TABLE[r][2]], msg_block[PERM_TABLE[r][3]]);
         mix_g(2, 6, 10, 14, msg_block[PERM_TABLE[r][4]], msg_block[PERM_TABLE[r][5]]);
         mix_g(3, 7, 11, 15, msg_block[PERM_TABLE[r][6]], msg_block[PERM_TABLE[r][7]]);
         mix_g(0, 5, 10, 15, msg_block[PERM_TABLE[r][8]], msg_block[PERM_TABLE[r][9]]);
         mix_g(1, 6, 11, 12, msg_block[PERM_TABLE[r][10]], msg_block[PERM_TABLE[r][11]]);
         mix_g(2, 7, 8, 13, msg_block[PERM_TABLE[r][12]], msg_block[PERM_TABLE[r][13]]);
         mix_g(3, 4, 9, 14, msg_block[PERM_TABLE[r][14]], msg_block[PERM_TABLE[r][15]]);
      end
      for (int i = 0; i < 8; i++) chain[i] ^= vec[i] ^ vec[i + 8];
   endfunction

   function automatic void absorb_word(logic [31:0] w, logic [2:0] bv_in, logic last_in);
      int bv;
      int dl;
      int kl;
      int n;
      bit key_part;
      digest_item_type d;
      bv = (bv_in > 4) ? 4 : bv_in;
      dl = (digest_len_reg == 0) ? 1 : ((digest_len_reg > 32) ? 32 : digest_len_reg);
      kl = (key_len_reg > 32) ? 32 : key_len_reg;
      if (at_start) begin
         for (int i = 0; i < 8; i++) chain[i] = IV_WORDS[i];
         chain[0] ^= PARAM_BASE ^ 32'(kl << 8) ^ 32'(dl);
         byte_total = 0;
         block_fill = 0;
         at_start = 0;
      end
      key_part = (kl != 0) && (byte_total < 64);
      if (key_part || bv != 0) begin
         if (block_fill >= BLOCK_WORDS) begin
            compress_block(0);
            block_fill = 0;
         end
         msg_block[block_fill] = w & keep_bytes(bv);
         block_fill++;
         byte_total += key_part ? 4 : bv;
      end
      if (!last_in) return;
      if (kl != 0 && byte_total < 64) byte_total = 64;
      for (int i = block_fill; i < BLOCK_WORDS; i++) msg_block[i] = 0;
      compress_block(1);
      n = (dl + 3) / 4;
      for (int k = 0; k < n; k++) begin
         d.word = chain[k] & keep_bytes(dl - 4 * k);
         d.index = 3'(k);
         d.last = (k == n - 1);
         digest_q.push_back(d);
      end
      at_start = 1;
      block_fill = 0;
   endfunction

   function automatic void note_miss(string what, digest_item_type e, digest_item_type a);
      misses++;
      if (misses <= 10)
         $display("%0t: %s: expected %h/%0d/%0b, got %h/%0d/%0b", $realtime, what,
                  e.word, e.index, e.last, a.word, a.index, a.last);
   endfunction

   always @(posedge clock) begin
      digest_item_type got;
      digest_item_type want;
      if (reset) begin
         digest_q.delete();
         digest_len_reg = 6'd32;
         key_len_reg = 6'd0;
         block_fill = 0;
         byte_total = 0;
         at_start = 1;
         misses = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_DIGEST_LENGTH) digest_len_reg = csr_write_data;
            else key_len_reg = csr_write_data;
         end
         if (req_channel.valid && req_channel.ready)
            absorb_word(req_channel.message_word, req_channel.bytes_valid,
                        req_channel.last_word);
         if (rsp_channel.valid && rsp_channel.ready) begin
            got.word = rsp_channel.digest_word;
            got.index = rsp_channel.word_index;
            got.last = rsp_channel.last_result;
            if (digest_q.size() == 0) begin
               want = '{default: 'x};
               note_miss("unexpected digest item", want, got);
            end else begin
               want = digest_q.pop_front();
               if (got.word !== want.word || got.index !== want.index
                   || got.last !== want.last)
                  note_miss("digest mismatch", want, got);
            end
         end
      end
      pending <= digest_q.size();
      fail_count <= misses;
   end

endmodule

### test/blake2s_hash_engine_tb.sv
`timescale 1ns / 100ps

module blake2s_hash_engine_tb;
   import blk2s_pkg::*;

   logic clock = 0;
   logic reset;
   logic csr_write_enable;
   logic csr_index;
   logic [5:0] csr_write_data;
   int fail_count;
   int pending;
   bit idle_on = 1;
   bit hold_ask = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   int key_setting = 0;

   blk2s_req_if req_if();
   blk2s_rsp_if rsp_if();

   blake2s_hash_engine u_dut (
      .clock(clock),
      .reset(reset),
      .req_channel(req_if),
      .rsp_channel(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   blake2s_hash_engine_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_channel(req_if),
      .rsp_channel(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .fail_count(fail_count),
      .pending(pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
      end else if (hold_ask) begin
         hold_ask = 0;
         hold_left = 300;
         rsp_if.ready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 0;
      end else begin
         rsp_if.ready <= !idle_on || $urandom_range(99) >= 37;
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 20000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_item(logic [31:0] w, logic [2:0] bv, logic lw);
      if (idle_on)
         while ($urandom_range(99) < 37) begin
            req_if.valid <= 0;
            @(posedge clock);
         end
      req_if.valid <= 1;
      req_if.message_word <= w;
      req_if.bytes_valid <= bv;
      req_if.last_word <= lw;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      req_if.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_regs(logic [5:0] dl, logic [5:0] kl);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= CSR_DIGEST_LENGTH;
      csr_write_data <= dl;
      @(posedge clock);
      csr_index <= CSR_KEY_LENGTH;
      csr_write_data <= kl;
      @(posedge clock);
      csr_write_enable <= 0;
      key_setting = kl;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return 32'hFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_message(inout int sent);
      int key_words;
      int body_words;
      int total;
      logic [2:0] bv;
      bit lw;
      key_words = (key_setting != 0) ? 16 : 0;
      body_words = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 12);
      if (key_words != 0 && $urandom_range(9) == 0) begin
         key_words = $urandom_range(1, 16);
         body_words = 0;
      end
      total = key_words + body_words;
      if (total == 0) begin
         send_item(pick_word(), 3'($urandom_range(0, 7) == 0 ? 5 : 0), 1);
         sent++;
         return;
      end
      for (int i = 0; i < total; i++) begin
         lw = (i == total - 1);
         bv = 3'd4;
         if ($urandom_range(9) == 0) bv = 3'($urandom_range(0, 7));
         if (lw && body_words > 0 && $urandom_range(1)) bv = 3'($urandom_range(0, 4));
         send_item(pick_word(), bv, lw);
         sent++;
      end
   endtask

   initial begin
      int sent;
      logic [5:0] dl_set[6];
      logic [5:0] kl_set[6];
      reset <= 1;
      csr_write_enable <= 0;
      csr_index <= CSR_DIGEST_LENGTH;
      csr_write_data <= 0;
      req_if.valid <= 0;
      req_if.message_word <= 0;
      req_if.bytes_valid <= 0;
      req_if.last_word <= 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      key_setting = 0;
      send_item(32'h0, 3'd0, 1);
      send_item(32'hFFFFFFFF, 3'd4, 1);
      send_item(32'h12345678, 3'd7, 1);
      send_item(32'hA5A5A5A5, 3'd4, 0);
      send_item(32'hDEADBEEF, 3'd0, 0);
      send_item(32'hCAFEF00D, 3'd2, 0);
      send_item(32'h87654321, 3'd3, 1);
      for (int i = 0; i < 17; i++)
         send_item(i[0] ? 32'h0 : 32'hFFFFFFFF, 3'd4, i == 16);
      drain();
      set_regs(6'd1, 6'd32);
      for (int i = 0; i < 5; i++) send_item($urandom, 3'd4, i == 4);
      drain();

      dl_set = '{6'd32, 6'd0, 6'd63, 6'd20, 6'd16, 6'($urandom_range(1, 63))};
      kl_set = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd5, 6'($urandom_range(0, 63))};
      for (int p = 0; p < 6; p++) begin
         set_regs(dl_set[p], kl_set[p]);
         idle_on = (p != 2);
         if (p == 3) hold_ask = 1;
         sent = 0;
         while (sent < 10) random_message(sent);
         drain();
      end
      idle_on = 1;

      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### filelist.f
rtl/core/blk2s_pkg.sv
rtl/core/blk2s_req_if.sv
rtl/core/blk2s_rsp_if.sv
rtl/core/blk2s_front.sv
rtl/core/blk2s_queue.sv
rtl/core/blk2s_back.sv
rtl/core/blake2s_hash_engine.sv
test/blake2s_hash_engine_checker.sv
test/blake2s_hash_engine_tb.sv
